/* sv/bpfa_pkg.sv */
package bpfa_pkg;

    localparam int PAGE_W = 16;
    localparam int CNT_W  = 17;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        MODE_LOCK      = 2'd0,
        MODE_UNRESERVE = 2'd1,
        MODE_ALLOC     = 2'd2,
        MODE_FREE      = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_ALREADY = 2'd1,
        STATUS_RANGE   = 2'd2,
        STATUS_OOM     = 2'd3
    } t_status;

    // register index, taken from paddr above the byte offset
    localparam logic REG_PAGE_LIMIT = 1'b0;

    localparam logic [CNT_W-1:0] CNT_MAX        = '1;
    localparam logic [CNT_W-1:0] PAGE_LIMIT_RST = 17'd65536;

endpackage

/* sv/bpfa_req_if.sv */
interface bpfa_req_if;
    logic                          valid;
    logic                          ready;
    bpfa_pkg::t_mode               mode;
    logic [bpfa_pkg::PAGE_W-1:0]   page;

    modport source (output valid, mode, page, input ready);
    modport sink   (input valid, mode, page, output ready);
endinterface

/* sv/bpfa_rsp_if.sv */
interface bpfa_rsp_if;
    logic                          valid;
    logic                          ready;
    bpfa_pkg::t_status             status;
    logic [bpfa_pkg::PAGE_W-1:0]   result_page;
    logic [bpfa_pkg::CNT_W-1:0]    free_pages;
    logic [bpfa_pkg::CNT_W-1:0]    used_pages;
    logic [bpfa_pkg::CNT_W-1:0]    reserved_pages;

    modport source (output valid, status, result_page, free_pages, used_pages,
                    reserved_pages, input ready);
    modport sink   (input valid, status, result_page, free_pages, used_pages,
                    reserved_pages, output ready);
endinterface

/* sv/bitmap_page_frame_allocator_top.sv */
// Bitmap page-frame allocator, first fit from a search hint.
// i_req carries one request (mode, page) per valid/ready transfer; o_rsp returns
// exactly one response per request (status, result page and the free, used and
// reserved counts after the request). page_limit sits behind the APB port at
// offset 0 and is to be written only while no request is in flight; the block
// itself does not enforce this. The bitmap lives in one single-port-write memory
// of NUM_WORDS words with a registered read. For lock, unreserve and free the
// bitmap word is read when the request is accepted, then modified and written
// back in S_EVAL, which also loads the response register and sets o_rsp.valid;
// that step waits while an older response is still held on o_rsp. Alloc reads
// one further word for each word it scans past the hint word, usually none. A
// new request is accepted only after the current one is done, set by the read
// then write of the bitmap memory. After reset the block sweeps the bitmap to
// zero, one word a cycle, over all NUM_WORDS words (1024 at the default
// parameters); i_req.ready stays low during the sweep while APB writes are taken as usual.
// The response sits in an output register; a new request is accepted while it
// waits, and the next response is held back until o_rsp.ready takes the old one.
module bitmap_page_frame_allocator_top #(
    parameter int MAX_PAGES = 65536,
    parameter int WORD_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bpfa_req_if.sink                      i_req,
    bpfa_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfa_pkg::APB_AW-1:0]   paddr,
    input  logic [bpfa_pkg::APB_DW-1:0]   pwdata,
    output logic [bpfa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bpfa_pkg::*;

    // storage word is the largest power of two not above WORD_BITS
    localparam int BIT_W     = $clog2(WORD_BITS + 1) - 1;
    localparam int BW        = 1 << BIT_W;
    // the page limit register caps the reachable pages
    localparam int LIM_CAP   = (MAX_PAGES < 131071) ? MAX_PAGES : 131071;
    localparam int NUM_WORDS = (LIM_CAP + BW - 1) / BW;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WA_W      = CNT_W - BIT_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_page_limit;
    logic [CNT_W-1:0]       r_used;
    logic [CNT_W-1:0]       r_res;
    logic [CNT_W-1:0]       r_hint;
    t_mode                  r_mode;
    logic [PAGE_W-1:0]      r_page;
    logic [WA_W-1:0]        r_wa;
    logic                   r_first;
    logic [AW-1:0]          r_clr_addr;
    logic                   r_out_valid;
    t_status                r_status;
    logic [PAGE_W-1:0]      r_res_page;
    logic [CNT_W-1:0]       r_free;

    logic [BW-1:0]          mem [NUM_WORDS];
    logic [BW-1:0]          r_rdata;

    logic [CNT_W-1:0]       lim;
    logic                   accept;
    logic                   out_free;
    logic [WA_W-1:0]        lim_word;
    logic [BIT_W-1:0]       lim_bit;
    logic [BW-1:0]          hi_mask;
    logic [BW-1:0]          lo_mask;
    logic [BW-1:0]          avail;
    logic                   found;
    logic [BIT_W-1:0]       idx;
    logic [WA_W:0]          next_word;
    logic                   more;
    logic                   scan_on;
    logic                   finish;
    logic [BIT_W-1:0]       bit_idx;
    logic                   cur_bit;

    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    logic [BW-1:0]          w_wdata;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;

    t_status                n_status;
    logic [PAGE_W-1:0]      n_res_page;
    logic [CNT_W-1:0]       n_used;
    logic [CNT_W-1:0]       n_res;
    logic [CNT_W-1:0]       n_hint;
    logic [CNT_W-1:0]       n_free;
    logic [CNT_W:0]         taken;
    logic                   mod_we;
    logic [BW-1:0]          mod_wdata;
    logic [WA_W-1:0]        req_wa;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_PAGE_LIMIT)
                  ? APB_DW'(r_page_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_limit <= PAGE_LIMIT_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[APB_AW-1:2] == REG_PAGE_LIMIT) begin
            r_page_limit <= pwdata[CNT_W-1:0];
        end
    end

    assign lim      = (r_page_limit < CNT_W'(LIM_CAP)) ? r_page_limit : CNT_W'(LIM_CAP);
    assign lim_word = lim[CNT_W-1:BIT_W];
    assign lim_bit  = lim[BIT_W-1:0];

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    // word to read for a new request: hint word for alloc, page word otherwise
    assign req_wa = (i_req.mode == MODE_ALLOC) ? r_hint[CNT_W-1:BIT_W]
                                               : WA_W'(i_req.page[PAGE_W-1:BIT_W]);

    // alloc scan over the word in r_rdata
    always_comb begin
        if (r_wa < lim_word) begin
            hi_mask = '1;
        end else if (r_wa == lim_word) begin
            hi_mask = (BW'(1) << lim_bit) - BW'(1);
        end else begin
            hi_mask = '0;
        end
        lo_mask = r_first ? ~((BW'(1) << r_hint[BIT_W-1:0]) - BW'(1)) : '1;
    end

    assign avail = ~r_rdata & hi_mask & lo_mask;
    assign found = |avail;

    always_comb begin
        idx = '0;
        for (int i = BW - 1; i >= 0; i--) begin
            if (avail[i]) begin
                idx = BIT_W'(i);
            end
        end
    end

    assign next_word = {1'b0, r_wa} + (WA_W + 1)'(1);
    assign more      = {next_word, {BIT_W{1'b0}}} < {1'b0, lim};
    assign scan_on   = (r_state == S_EVAL) && (r_mode == MODE_ALLOC) && !found && more;
    assign finish    = (r_state == S_EVAL) && !scan_on && out_free;

    assign bit_idx = r_page[BIT_W-1:0];
    assign cur_bit = r_rdata[bit_idx];

    // request evaluation on the word just read
    always_comb begin
        n_status   = STATUS_DONE;
        n_res_page = r_page;
        n_used     = r_used;
        n_res      = r_res;
        n_hint     = r_hint;
        mod_we     = 1'b0;
        mod_wdata  = r_rdata;
        if (r_mode == MODE_ALLOC) begin
            if (found) begin
                mod_we     = 1'b1;
                mod_wdata  = r_rdata | (BW'(1) << idx);
                n_used     = (r_used == CNT_MAX) ? CNT_MAX : r_used + CNT_W'(1);
                n_hint     = {r_wa, idx};
                n_res_page = PAGE_W'({r_wa, idx});
            end else begin
                n_status   = STATUS_OOM;
                n_res_page = '0;
                n_hint     = lim;
            end
        end else if ({1'b0, r_page} >= lim) begin
            n_status = STATUS_RANGE;
        end else begin
            unique case (r_mode)
                MODE_LOCK: begin
                    if (cur_bit) begin
                        n_status = STATUS_ALREADY;
                    end else begin
                        mod_we    = 1'b1;
                        mod_wdata = r_rdata | (BW'(1) << bit_idx);
                        n_res     = (r_res == CNT_MAX) ? CNT_MAX : r_res + CNT_W'(1);
                    end
                end
                MODE_UNRESERVE, MODE_FREE: begin
                    if (!cur_bit) begin
                        n_status = STATUS_ALREADY;
                    end else begin
                        mod_we    = 1'b1;
                        mod_wdata = r_rdata & ~(BW'(1) << bit_idx);
                        if (r_mode == MODE_UNRESERVE) begin
                            n_res = (r_res == '0) ? '0 : r_res - CNT_W'(1);
                        end else begin
                            n_used = (r_used == '0) ? '0 : r_used - CNT_W'(1);
                        end
                        if (r_hint > {1'b0, r_page}) begin
                            n_hint = {1'b0, r_page};
                        end
                    end
                end
                default: begin
                    n_status = STATUS_DONE;
                end
            endcase
        end
        taken  = {1'b0, n_used} + {1'b0, n_res};
        n_free = (taken >= {1'b0, lim}) ? '0 : lim - taken[CNT_W-1:0];
    end

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_wa[AW-1:0];
        w_wdata = mod_wdata;
        w_re    = 1'b0;
        w_raddr = req_wa[AW-1:0];
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (finish) begin
            w_we = mod_we;
        end
        if (accept) begin
            w_re = 1'b1;
        end else if (scan_on) begin
            w_re    = 1'b1;
            w_raddr = next_word[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // request sequencing and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_used      <= '0;
            r_res       <= '0;
            r_hint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(NUM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_mode  <= i_req.mode;
                        r_page  <= i_req.page;
                        r_wa    <= req_wa;
                        r_first <= 1'b1;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (scan_on) begin
                        r_wa    <= next_word[WA_W-1:0];
                        r_first <= 1'b0;
                    end else if (finish) begin
                        r_used      <= n_used;
                        r_res       <= n_res;
                        r_hint      <= n_hint;
                        r_status    <= n_status;
                        r_res_page  <= n_res_page;
                        r_free      <= n_free;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.result_page    = r_res_page;
    assign o_rsp.free_pages     = r_free;
    assign o_rsp.used_pages     = r_used;
    assign o_rsp.reserved_pages = r_res;

endmodule
